// ===== hw/rtl/ealloc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ealloc_pkg
// Shared constants, command and status codes, and the control/status
// structs exchanged between the allocator controller and datapath.
// ----------------------------------------------------------------------------
package ealloc_pkg;

    // Default number of IDs handed out by the allocator
    localparam int MAX_IDS_DEF = 1024;

    // Field widths of the command and result words
    localparam int CMD_W    = 3;
    localparam int EID_W    = 10;
    localparam int MASK_W   = 64;
    localparam int STATUS_W = 2;
    localparam int ACTIVE_W = 11;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TEST    = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
    } ctrl_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ealloc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ealloc_req_if
// Command channel: valid/ready handshake with the command word payload.
// ----------------------------------------------------------------------------
interface ealloc_req_if;

    logic                              valid;
    logic                              ready;
    logic [ealloc_pkg::CMD_W-1:0]      cmd;
    logic [ealloc_pkg::EID_W-1:0]      entity_id;
    logic [ealloc_pkg::MASK_W-1:0]     mask_in;

    modport source (output valid, output cmd, output entity_id, output mask_in,
                    input ready);
    modport sink   (input valid, input cmd, input entity_id, input mask_in,
                    output ready);

endinterface
`default_nettype wire

// ===== hw/rtl/ealloc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ealloc_rsp_if
// Result channel: valid/ready handshake with the result word payload.
// ----------------------------------------------------------------------------
interface ealloc_rsp_if;

    logic                              valid;
    logic                              ready;
    logic [ealloc_pkg::EID_W-1:0]      id_out;
    logic [ealloc_pkg::MASK_W-1:0]     mask_out;
    logic                              has_bits;
    logic [ealloc_pkg::STATUS_W-1:0]   status;
    logic [ealloc_pkg::ACTIVE_W-1:0]   active_out;

    modport source (output valid, output id_out, output mask_out, output has_bits,
                    output status, output active_out, input ready);
    modport sink   (input valid, input id_out, input mask_out, input has_bits,
                    input status, input active_out, output ready);

endinterface
`default_nettype wire

// ===== hw/rtl/entity_id_allocator_with_masks.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// entity_id_allocator_with_masks
// LIFO free-list ID allocator keeping one 64-bit mask per ID.
// ----------------------------------------------------------------------------
// After reset the block sweeps every entry of the mask memory to zero
// and holds req.ready low until the sweep is done. Each command is then
// accepted in a cycle that reads the free stack and the mask memory, and
// executes against the registered read data once the result register is
// free, loading the result register. No new command is accepted while
// one awaits execution; a result left waiting is held in the result
// register while the next command is accepted and read, and that command
// executes as soon as the waiting word is taken. The first create hands
// out MAX_IDS-1; destroy on a full free stack reports status 2 and changes
// nothing.
// ----------------------------------------------------------------------------
module entity_id_allocator_with_masks #(
    parameter int MAX_IDS = ealloc_pkg::MAX_IDS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ealloc_req_if.sink    req,
    ealloc_rsp_if.source  rsp
);

    ealloc_pkg::ctrl_cmd_t  cmd;
    ealloc_pkg::ctrl_stat_t stat;

    ealloc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ealloc_dp #(
        .MAX_IDS (MAX_IDS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_cmd       (req.cmd),
        .in_entity_id (req.entity_id),
        .in_mask      (req.mask_in),
        .id_out       (rsp.id_out),
        .mask_out     (rsp.mask_out),
        .has_bits     (rsp.has_bits),
        .status       (rsp.status),
        .active_out   (rsp.active_out)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/ealloc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ealloc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data held while the read enable is low.
// ----------------------------------------------------------------------------
module ealloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ealloc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ealloc_ctrl
// Allocator controller: sequences the mask clearing pass after reset,
// command capture, execution and the result word handshake.
// ----------------------------------------------------------------------------
module ealloc_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output ealloc_pkg::ctrl_cmd_t       cmd,
    input  wire ealloc_pkg::ctrl_stat_t stat
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // Result register can take a new word when empty or being drained
    assign slot_free = !out_valid_reg || rsp_ready;

    // Commands to the datapath
    always_comb
    begin
        cmd            = '0;
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.capture    = (state_reg == ST_IDLE) && req_valid;
        cmd.execute    = (state_reg == ST_EXEC) && slot_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on execute, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ealloc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ealloc_dp
// Allocator datapath: free ID stack and per-ID mask memories, stack
// pointers, active counter, command capture and the result register.
// ----------------------------------------------------------------------------
module ealloc_dp #(
    parameter int MAX_IDS = ealloc_pkg::MAX_IDS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ealloc_pkg::ctrl_cmd_t                cmd,
    output ealloc_pkg::ctrl_stat_t                    stat,
    input  wire logic [ealloc_pkg::CMD_W-1:0]         in_cmd,
    input  wire logic [ealloc_pkg::EID_W-1:0]         in_entity_id,
    input  wire logic [ealloc_pkg::MASK_W-1:0]        in_mask,
    output logic      [ealloc_pkg::EID_W-1:0]         id_out,
    output logic      [ealloc_pkg::MASK_W-1:0]        mask_out,
    output logic                                      has_bits,
    output logic      [ealloc_pkg::STATUS_W-1:0]      status,
    output logic      [ealloc_pkg::ACTIVE_W-1:0]      active_out
);

    localparam int IDW = $clog2(MAX_IDS);
    localparam int CW  = $clog2(MAX_IDS + 1);
    localparam int AW  = (IDW > ealloc_pkg::EID_W) ? IDW : ealloc_pkg::EID_W;
    localparam int MW  = ealloc_pkg::MASK_W;

    localparam logic [CW-1:0]  TOP_FULL = CW'(MAX_IDS);
    localparam logic [AW:0]    EID_LIM  = (AW + 1)'(MAX_IDS);
    localparam logic [IDW-1:0] CLR_LAST = IDW'(MAX_IDS - 1);

    // Stack pointer, lowest pointer ever reached, active count, clear sweep
    logic [CW-1:0]  top_reg, top_next;
    logic [CW-1:0]  low_reg, low_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [IDW-1:0] clr_reg;

    // Captured command word
    logic [ealloc_pkg::CMD_W-1:0] cmd_reg;
    logic [ealloc_pkg::EID_W-1:0] eid_reg;
    logic [MW-1:0]                mask_reg;

    // Result word
    logic [ealloc_pkg::EID_W-1:0]    id_reg, id_next;
    logic [MW-1:0]                   mout_reg, mout_next;
    logic                            hb_reg, hb_next;
    logic [ealloc_pkg::STATUS_W-1:0] st_reg, st_next;

    // Memory ports
    logic           s_we, m_we;
    logic [IDW-1:0] s_waddr, m_waddr, s_raddr, m_raddr;
    logic [IDW-1:0] s_wdata, s_rdata;
    logic [MW-1:0]  m_wdata, m_rdata;

    // Decode helpers
    logic [AW-1:0]  in_eid_ext, eid_ext;
    logic           eid_ok;
    logic [IDW-1:0] eid_idx;
    logic [CW-1:0]  top_dec;
    logic           empty, full, fresh;
    logic [IDW-1:0] got;

    assign in_eid_ext = AW'(in_entity_id);
    assign eid_ext    = AW'(eid_reg);
    assign eid_ok     = {1'b0, eid_ext} < EID_LIM;
    assign eid_idx    = eid_ext[IDW-1:0];
    assign top_dec    = top_reg - CW'(1);
    assign empty      = (top_reg == '0);
    assign full       = (top_reg == TOP_FULL);
    // Slots below the lowest pointer ever reached still hold their reset value
    assign fresh      = (top_reg == low_reg);
    assign got        = fresh ? top_dec[IDW-1:0] : s_rdata;

    // Read addresses issued on capture
    assign s_raddr = top_dec[IDW-1:0];
    assign m_raddr = in_eid_ext[IDW-1:0];

    ealloc_ram #(
        .WIDTH (IDW),
        .DEPTH (MAX_IDS)
    ) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (cmd.capture),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    ealloc_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_IDS)
    ) u_masks (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (cmd.capture),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    // Execute: memory writes, pointer and counter updates, result word
    always_comb
    begin
        s_we       = 1'b0;
        s_waddr    = top_reg[IDW-1:0];
        s_wdata    = eid_idx;
        m_we       = 1'b0;
        m_waddr    = clr_reg;
        m_wdata    = '0;
        top_next   = top_reg;
        low_next   = low_reg;
        count_next = count_reg;
        id_next    = '0;
        mout_next  = '0;
        hb_next    = 1'b0;
        st_next    = ealloc_pkg::STAT_OK;
        if (cmd.clear_step)
        begin
            m_we = 1'b1;
        end
        else if (cmd.execute)
        begin
            case (cmd_reg)
                ealloc_pkg::CMD_CREATE:
                begin
                    if (empty)
                    begin
                        st_next = ealloc_pkg::STAT_NO_FREE;
                    end
                    else
                    begin
                        top_next   = top_dec;
                        low_next   = fresh ? top_dec : low_reg;
                        m_we       = 1'b1;
                        m_waddr    = got;
                        count_next = count_reg + CW'(1);
                        id_next    = ealloc_pkg::EID_W'(got);
                    end
                end
                ealloc_pkg::CMD_DESTROY:
                begin
                    if (eid_ok)
                    begin
                        if (full)
                        begin
                            st_next = ealloc_pkg::STAT_FULL;
                        end
                        else
                        begin
                            s_we     = 1'b1;
                            top_next = top_reg + CW'(1);
                            m_we     = 1'b1;
                            m_waddr  = eid_idx;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                    end
                end
                ealloc_pkg::CMD_GET:
                begin
                    if (eid_ok)
                    begin
                        mout_next = m_rdata;
                    end
                end
                ealloc_pkg::CMD_SET:
                begin
                    if (eid_ok)
                    begin
                        m_we    = 1'b1;
                        m_waddr = eid_idx;
                        m_wdata = mask_reg;
                    end
                end
                ealloc_pkg::CMD_RESET:
                begin
                    if (eid_ok)
                    begin
                        m_we    = 1'b1;
                        m_waddr = eid_idx;
                    end
                end
                ealloc_pkg::CMD_TEST:
                begin
                    hb_next = eid_ok && (|(m_rdata & mask_reg));
                end
                default:
                begin
                    st_next = ealloc_pkg::STAT_OK;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= TOP_FULL;
            low_reg   <= TOP_FULL;
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            top_reg   <= top_next;
            low_reg   <= low_next;
            count_reg <= count_next;
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + IDW'(1);
            end
        end
    end

    // Capture the command word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= in_cmd;
            eid_reg  <= in_entity_id;
            mask_reg <= in_mask;
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            id_reg   <= id_next;
            mout_reg <= mout_next;
            hb_reg   <= hb_next;
            st_reg   <= st_next;
        end
    end

    always_comb
    begin
        stat            = '0;
        stat.clear_done = cmd.clear_step && (clr_reg == CLR_LAST);
    end

    assign id_out     = id_reg;
    assign mask_out   = mout_reg;
    assign has_bits   = hb_reg;
    assign status     = st_reg;
    assign active_out = ealloc_pkg::ACTIVE_W'(count_reg);

endmodule
`default_nettype wire

// ===== verif/entity_id_allocator_with_masks_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entity_id_allocator_with_masks_test
// Self-checking bench for the LIFO ID allocator with per-ID masks. A local
// model of the free list, the mask store and the active count predicts
// every result word. A checker compares each accepted result word field by
// field with the oldest prediction. The stimulus starts with directed
// commands. Random traffic follows in several phases with different idle
// patterns, and one phase drains the free list until creates are refused.
// ----------------------------------------------------------------------------
module entity_id_allocator_with_masks_test;

    import ealloc_pkg::*;

    localparam int MAX_IDS     = MAX_IDS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // Command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic [EID_W-1:0]    id_out;
        logic [MASK_W-1:0]   mask_out;
        logic                has_bits;
        logic [STATUS_W-1:0] status;
        logic [ACTIVE_W-1:0] active_out;
    } alloc_result_t;

    logic clk;
    logic rst_n;

    ealloc_req_if req_ch ();
    ealloc_rsp_if rsp_ch ();

    entity_id_allocator_with_masks #(
        .MAX_IDS (MAX_IDS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Allocator model state
    logic [EID_W-1:0]    free_ids [MAX_IDS];
    int                  free_top;
    logic [MASK_W-1:0]   stored_masks [MAX_IDS];
    logic [ACTIVE_W-1:0] live_count;

    // Predicted result words, oldest first, and IDs currently handed out
    alloc_result_t    pending_results [$];
    alloc_result_t    head_result;
    logic [EID_W-1:0] held_ids [$];

    int send_gap_pct     = 0;
    int sink_stall_pct   = 0;
    int mismatches       = 0;
    int words_sent       = 0;
    int results_seen     = 0;
    int refused_creates  = 0;
    int refused_destroys = 0;
    int cycles           = 0;

    // Clock generation
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Load the model with the post-reset state
    function automatic void reset_allocator_model();
        for (int i = 0; i < MAX_IDS; i++)
        begin
            free_ids[i]     = EID_W'(i);
            stored_masks[i] = '0;
        end
        free_top   = MAX_IDS;
        live_count = '0;
    endfunction

    // Apply one command word to the model and return the result word
    function automatic alloc_result_t apply_command(input logic [CMD_W-1:0] op,
                                                    input logic [EID_W-1:0] eid,
                                                    input logic [MASK_W-1:0] bits);
        alloc_result_t    r;
        logic [EID_W-1:0] got;
        bit               in_range;
        r        = '0;
        in_range = (int'(eid) < MAX_IDS);
        case (op)
            CMD_CREATE:
            begin
                if (free_top == 0)
                begin
                    r.status = STAT_NO_FREE;
                end
                else
                begin
                    free_top--;
                    got               = EID_W'(int'(free_ids[free_top]) % MAX_IDS);
                    stored_masks[got] = '0;
                    live_count++;
                    r.id_out          = got;
                end
            end
            CMD_DESTROY:
            begin
                if (in_range)
                begin
                    if (free_top >= MAX_IDS)
                    begin
                        r.status = STAT_FULL;
                    end
                    else
                    begin
                        free_ids[free_top] = eid;
                        free_top++;
                        stored_masks[eid]  = '0;
                        if (live_count != 0)
                            live_count--;
                    end
                end
            end
            CMD_GET:
            begin
                if (in_range)
                    r.mask_out = stored_masks[eid];
            end
            CMD_SET:
            begin
                if (in_range)
                    stored_masks[eid] = bits;
            end
            CMD_RESET:
            begin
                if (in_range)
                    stored_masks[eid] = '0;
            end
            CMD_TEST:
            begin
                if (in_range)
                    r.has_bits = ((stored_masks[eid] & bits) != '0);
            end
            default:
            begin
            end
        endcase
        r.active_out = live_count;
        return r;
    endfunction

    // Pick a mask: empty, full, one bit, or fully random
    function automatic logic [MASK_W-1:0] random_mask();
        logic [MASK_W-1:0] m;
        case ($urandom_range(7))
            0:       m = '0;
            1:       m = '1;
            2:       m = 64'd1 << $urandom_range(MASK_W-1);
            default: m = {$urandom(), $urandom()};
        endcase
        return m;
    endfunction

    // Send one command word, predict its result and track handed-out IDs
    task automatic send_word(input logic [CMD_W-1:0] op,
                             input logic [EID_W-1:0] eid,
                             input logic [MASK_W-1:0] bits);
        alloc_result_t r;
        int            hits [$];
        @(negedge clk);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= op;
        req_ch.entity_id <= eid;
        req_ch.mask_in   <= bits;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        r = apply_command(op, eid, bits);
        pending_results.push_back(r);
        words_sent++;
        // Keep the list of live IDs in step for targeted stimulus
        if (op == CMD_CREATE)
        begin
            if (r.status == STAT_OK)
                held_ids.push_back(r.id_out);
            else
                refused_creates++;
        end
        else if (op == CMD_DESTROY)
        begin
            if (r.status == STAT_FULL)
            begin
                refused_destroys++;
            end
            else
            begin
                hits = held_ids.find_first_index(x) with (x == eid);
                if (hits.size() != 0)
                    held_ids.delete(hits[0]);
            end
        end
    endtask

    // Send one random word; most IDs target live entries
    task automatic send_random_word(input int create_pct, input int destroy_pct);
        int                roll;
        logic [CMD_W-1:0]  op;
        logic [EID_W-1:0]  eid;
        roll = $urandom_range(99);
        eid  = EID_W'($urandom_range(MAX_IDS-1));
        if (held_ids.size() != 0 && $urandom_range(4) != 0)
            eid = held_ids[$urandom_range(held_ids.size()-1)];
        if (roll < create_pct)
        begin
            op = CMD_CREATE;
        end
        else if (roll < create_pct + destroy_pct)
        begin
            op = CMD_DESTROY;
        end
        else
        begin
            case ($urandom_range(19))
                0:                  op = CMD_SPARE_A;
                1:                  op = CMD_SPARE_B;
                2, 3, 4, 5:         op = CMD_GET;
                6, 7, 8, 9, 10:     op = CMD_SET;
                11, 12, 13:         op = CMD_RESET;
                default:            op = CMD_TEST;
            endcase
        end
        send_word(op, eid, random_mask());
    endtask

    // Field extremes, every command and the corner cases, no idling
    task automatic test_directed_basics();
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        // Destroy right after reset: free list full, count held at zero
        send_word(CMD_DESTROY, 10'd0, '0);
        send_word(CMD_CREATE, 10'd0, '0);
        send_word(CMD_CREATE, 10'd1023, '1);
        send_word(CMD_GET, 10'd1023, '0);
        send_word(CMD_SET, 10'd1023, '1);
        send_word(CMD_GET, 10'd1023, '0);
        send_word(CMD_TEST, 10'd1023, 64'h8000_0000_0000_0000);
        send_word(CMD_TEST, 10'd1023, '0);
        send_word(CMD_SET, 10'd1022, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(CMD_TEST, 10'd1022, 64'h5555_5555_5555_5555);
        send_word(CMD_TEST, 10'd1022, 64'h2);
        send_word(CMD_RESET, 10'd1023, '0);
        send_word(CMD_GET, 10'd1023, '0);
        // Masks of IDs that were never handed out
        send_word(CMD_SET, 10'd0, 64'h0123_4567_89AB_CDEF);
        send_word(CMD_GET, 10'd0, '0);
        // Destroy clears the mask
        send_word(CMD_DESTROY, 10'd1022, '0);
        send_word(CMD_GET, 10'd1022, '0);
        // Destroy of an inactive ID pushes it again
        send_word(CMD_DESTROY, 10'd5, '0);
        send_word(CMD_DESTROY, 10'd1023, '1);
        send_word(CMD_CREATE, 10'd0, '0);
        send_word(CMD_SET, 10'd5, '1);
        send_word(CMD_CREATE, 10'd0, '0);
        // Spare command codes do nothing
        send_word(CMD_SPARE_A, 10'd1023, '1);
        send_word(CMD_SPARE_B, 10'd5, '1);
        send_word(CMD_GET, 10'd5, '0);
    endtask

    // Balanced random traffic without idling
    task automatic test_mixed_traffic();
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        repeat (100)
            send_random_word(35, 25);
    endtask

    // Create until the free list is empty, then keep creating
    task automatic test_drain_free_list();
        send_gap_pct   = 45;
        sink_stall_pct = 0;
        while (free_top != 0)
            send_random_word(88, 2);
        repeat (20)
            send_random_word(40, 0);
    endtask

    // Destroy-heavy traffic against a stalling receiver
    task automatic test_refill_free_list();
        send_gap_pct   = 0;
        sink_stall_pct = 45;
        repeat (160)
            send_random_word(5, 60);
    endtask

    // Random traffic with light idling on both sides
    task automatic test_mixed_both_idle();
        send_gap_pct   = 11;
        sink_stall_pct = 11;
        repeat (120)
            send_random_word(30, 30);
    endtask

    // Compare one field of a result word
    task automatic compare_field(input string field,
                                 input logic [MASK_W-1:0] want,
                                 input logic [MASK_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d: %s expected %h, got %h",
                         results_seen, field, want, got);
        end
    endtask

    // Drive the result ready with the current stall rate
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Check each accepted result word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: word arrived with nothing expected", results_seen);
            end
            else
            begin
                head_result = pending_results.pop_front();
                compare_field("id_out", head_result.id_out, rsp_ch.id_out);
                compare_field("mask_out", head_result.mask_out, rsp_ch.mask_out);
                compare_field("has_bits", head_result.has_bits, rsp_ch.has_bits);
                compare_field("status", head_result.status, rsp_ch.status);
                compare_field("active_out", head_result.active_out, rsp_ch.active_out);
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycles, pending_results.size());
            $display("entity_id_allocator_with_masks_test: FAIL");
            $finish;
        end
    end

    // Reset, run the tests in turn, drain and report
    initial
    begin
        req_ch.valid     = 1'b0;
        req_ch.cmd       = CMD_CREATE;
        req_ch.entity_id = '0;
        req_ch.mask_in   = '0;
        rst_n            = 1'b0;
        reset_allocator_model();
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_basics();
        test_mixed_traffic();
        test_drain_free_list();
        test_refill_free_list();
        test_mixed_both_idle();

        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8)
            @(posedge clk);

        $display("%0d command words sent, %0d result words checked, %0d mismatches",
                 words_sent, results_seen, mismatches);
        $display("%0d creates refused on an empty free list, %0d destroys refused on a full one",
                 refused_creates, refused_destroys);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("entity_id_allocator_with_masks_test: PASS");
        else
            $display("entity_id_allocator_with_masks_test: FAIL");
        $finish;
    end

endmodule
